/* rtl/dtc_pkg.sv */
// shared types and constants of the decision tree classifier
package dtc_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int LINK_COUNT    = 1024;
  localparam int FEATURE_COUNT = 64;
  localparam int CATEGORY_MAX  = 64;

  localparam int NODE_AW = $clog2(NODE_COUNT);
  localparam int LINK_AW = $clog2(LINK_COUNT);
  localparam int FEAT_AW = $clog2(FEATURE_COUNT);

  // item function codes
  localparam logic [1:0] FN_NODE     = 2'd0;
  localparam logic [1:0] FN_LINK     = 2'd1;
  localparam logic [1:0] FN_FEATURE  = 2'd2;
  localparam logic [1:0] FN_CLASSIFY = 2'd3;

  // node kinds
  localparam logic [1:0] KIND_LEAF = 2'd0;
  localparam logic [1:0] KIND_CONT = 2'd1;
  localparam logic [1:0] KIND_CAT  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_WRITE_DONE = 2'd0;
  localparam logic [1:0] STAT_LEAF       = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN    = 2'd2;
  localparam logic [1:0] STAT_LIMIT      = 2'd3;

  // register select (bit 2 of the byte address)
  localparam logic REG_ROOT  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  feature_sel;
    logic [31:0] threshold;
    logic [7:0]  label;
    logic [9:0]  link_a;
    logic [9:0]  link_b;
    logic [6:0]  category_count;
  } node_rec_t;

  localparam int NODE_W = $bits(node_rec_t);

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_rec_t          wdata;
    logic [NODE_AW-1:0] raddr;
  } node_port_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    logic [9:0]         wdata;
    logic [LINK_AW-1:0] raddr;
  } link_port_t;

  typedef struct packed {
    logic               we;
    logic [FEAT_AW-1:0] waddr;
    logic [31:0]        wdata;
    logic [FEAT_AW-1:0] raddr;
  } feat_port_t;

  typedef struct packed {
    logic [9:0]  root_index;
    logic [10:0] visit_limit;
  } cfg_t;

endpackage

/* rtl/decision_tree_classify_core.sv */
// top level of the decision tree classifier
//
// request channel (req_valid / req_stall): each beat carries one item. func
// selects a node record write, a child link write, a feature write or a
// classification of the stored sample. the block takes one item at a time:
// req_stall is high from the beat's acceptance until its result has been
// handed to the result stage.
// result channel (rsp_valid / rsp_stall): one beat per request. a beat held
// by rsp_stall keeps its payload; the next request is still taken while it
// waits, and its result queues in the sequencer until the output is free.
// timing: each tree level costs a node ram read, then a feature ram read,
// and a categorical level adds a child link ram read. a visit-limit stop
// takes the place of the next node read.
// configuration: apb registers root_index at 0x0 and visit_limit at 0x4, to be
// written only while the block is idle; the block itself does not enforce this.
// reset: registers return to root 0 and limit 1024, both channels go idle;
// the tree and feature rams keep their contents and must be loaded first.
module decision_tree_classify_core (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [9:0]  addr,
  input  logic [1:0]  kind,
  input  logic [5:0]  feature_sel,
  input  logic [31:0] value,
  input  logic [7:0]  label,
  input  logic [9:0]  link_a,
  input  logic [9:0]  link_b,
  input  logic [6:0]  category_count,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  result_label,
  output logic [1:0]  status,
  output logic [10:0] visits
);

  import dtc_pkg::*;

  cfg_t       cfg;
  node_port_t node_port;
  link_port_t link_port;
  feat_port_t feat_port;
  node_rec_t  node_rdata;
  logic [NODE_W-1:0] node_rbits;
  logic [9:0]        link_rdata;
  logic [31:0]       feat_rdata;
  logic              cfg_write;

  // apb: pready held high, bit 2 of the byte address picks the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_index  <= 10'd0;
      cfg.visit_limit <= 11'd1024;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ROOT:  cfg.root_index  <= pwdata[9:0];
        REG_LIMIT: cfg.visit_limit <= pwdata[10:0];
        default:   cfg.root_index  <= cfg.root_index;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROOT:  prdata = {22'd0, cfg.root_index};
      REG_LIMIT: prdata = {21'd0, cfg.visit_limit};
      default:   prdata = 32'd0;
    endcase
  end

  // node records: split test and child links share one entry
  dtc_ram #(.DEPTH(NODE_COUNT), .WIDTH(NODE_W)) u_node_ram (
    .clk   (clk),
    .we    (node_port.we),
    .waddr (node_port.waddr),
    .wdata (node_port.wdata),
    .raddr (node_port.raddr),
    .rdata (node_rbits)
  );

  assign node_rdata = node_rbits;

  // categorical child link slots
  dtc_ram #(.DEPTH(LINK_COUNT), .WIDTH(10)) u_link_ram (
    .clk   (clk),
    .we    (link_port.we),
    .waddr (link_port.waddr),
    .wdata (link_port.wdata),
    .raddr (link_port.raddr),
    .rdata (link_rdata)
  );

  // sample features
  dtc_ram #(.DEPTH(FEATURE_COUNT), .WIDTH(32)) u_feat_ram (
    .clk   (clk),
    .we    (feat_port.we),
    .waddr (feat_port.waddr),
    .wdata (feat_port.wdata),
    .raddr (feat_port.raddr),
    .rdata (feat_rdata)
  );

  dtc_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .func           (func),
    .addr           (addr),
    .kind           (kind),
    .feature_sel    (feature_sel),
    .value          (value),
    .label          (label),
    .link_a         (link_a),
    .link_b         (link_b),
    .category_count (category_count),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_label   (result_label),
    .status         (status),
    .visits         (visits),
    .node_port      (node_port),
    .link_port      (link_port),
    .feat_port      (feat_port),
    .node_rdata     (node_rdata),
    .link_rdata     (link_rdata),
    .feat_rdata     (feat_rdata)
  );

endmodule

/* rtl/dtc_ram.sv */
// simple dual-port synchronous ram, one write and one registered read
module dtc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dtc_walk.sv */
// item sequencer: memory writes, tree walk and result register
module dtc_walk (
  input  logic               clk,
  input  logic               rst,
  input  dtc_pkg::cfg_t      cfg,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic [9:0]         addr,
  input  logic [1:0]         kind,
  input  logic [5:0]         feature_sel,
  input  logic [31:0]        value,
  input  logic [7:0]         label,
  input  logic [9:0]         link_a,
  input  logic [9:0]         link_b,
  input  logic [6:0]         category_count,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [7:0]         result_label,
  output logic [1:0]         status,
  output logic [10:0]        visits,
  output dtc_pkg::node_port_t node_port,
  output dtc_pkg::link_port_t link_port,
  output dtc_pkg::feat_port_t feat_port,
  input  dtc_pkg::node_rec_t  node_rdata,
  input  logic [9:0]         link_rdata,
  input  logic [31:0]        feat_rdata
);

  import dtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_NODE,
    ST_FEAT,
    ST_LINK,
    ST_DONE
  } state_t;

  state_t             state;
  logic [NODE_AW-1:0] node;
  logic [10:0]        walk_visits;
  node_rec_t          rec;
  logic [7:0]         pend_label;
  logic [1:0]         pend_status;
  logic [10:0]        pend_visits;

  logic       accept;
  logic [6:0] cnt_clip;
  logic       feat_le;
  logic       code_bad;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign cnt_clip = (category_count > 7'(CATEGORY_MAX)) ? 7'(CATEGORY_MAX) : category_count;
  assign feat_le  = ($signed(feat_rdata) <= $signed(rec.threshold));
  assign code_bad = feat_rdata[31] || (feat_rdata >= {25'd0, rec.category_count});

  always_comb begin
    node_port.we                   = accept && (func == FN_NODE);
    node_port.waddr                = addr[NODE_AW-1:0];
    node_port.wdata.kind           = kind;
    node_port.wdata.feature_sel    = feature_sel;
    node_port.wdata.threshold      = value;
    node_port.wdata.label          = label;
    node_port.wdata.link_a         = link_a;
    node_port.wdata.link_b         = link_b;
    node_port.wdata.category_count = cnt_clip;
    node_port.raddr                = node;

    link_port.we    = accept && (func == FN_LINK);
    link_port.waddr = addr[LINK_AW-1:0];
    link_port.wdata = link_a;
    link_port.raddr = rec.link_a[LINK_AW-1:0] + feat_rdata[LINK_AW-1:0];

    feat_port.we    = accept && (func == FN_FEATURE) && (addr < 10'(FEATURE_COUNT));
    feat_port.waddr = addr[FEAT_AW-1:0];
    feat_port.wdata = value;
    // node record fresh from the ram selects the feature
    feat_port.raddr = node_rdata.feature_sel[FEAT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func == FN_CLASSIFY) begin
              node        <= cfg.root_index[NODE_AW-1:0];
              walk_visits <= 11'd0;
              state       <= ST_READ;
            end else begin
              pend_label  <= 8'd0;
              pend_status <= STAT_WRITE_DONE;
              pend_visits <= 11'd0;
              state       <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          if (walk_visits >= cfg.visit_limit) begin
            pend_label  <= 8'd0;
            pend_status <= STAT_LIMIT;
            pend_visits <= walk_visits;
            state       <= ST_DONE;
          end else begin
            walk_visits <= walk_visits + 11'd1;
            state       <= ST_NODE;
          end
        end
        ST_NODE: begin
          rec <= node_rdata;
          if (node_rdata.kind == KIND_CONT || node_rdata.kind == KIND_CAT) begin
            state <= ST_FEAT;
          end else begin
            pend_label  <= node_rdata.label;
            pend_status <= STAT_LEAF;
            pend_visits <= walk_visits;
            state       <= ST_DONE;
          end
        end
        ST_FEAT: begin
          if (rec.kind == KIND_CONT) begin
            node  <= feat_le ? rec.link_a[NODE_AW-1:0] : rec.link_b[NODE_AW-1:0];
            state <= ST_READ;
          end else if (code_bad) begin
            pend_label  <= rec.label;
            pend_status <= STAT_UNKNOWN;
            pend_visits <= walk_visits;
            state       <= ST_DONE;
          end else begin
            state <= ST_LINK;
          end
        end
        ST_LINK: begin
          node  <= link_rdata[NODE_AW-1:0];
          state <= ST_READ;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            result_label <= pend_label;
            status       <= pend_status;
            visits       <= pend_visits;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/dtc_check.sv */
// port-level checks of the classifier, bound to the top level
module dtc_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [7:0]  result_label,
  input logic [1:0]  status,
  input logic [10:0] visits
);

  import dtc_pkg::*;

  // a held result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(result_label) && $stable(status)
      && $stable(visits))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after a request beat
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous item in flight");

  // write acknowledgements carry no label and no visits
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_WRITE_DONE |-> result_label == 8'd0 && visits == 11'd0)
    else $error("write result with label or visits");

  // limit stop reports label zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_LIMIT |-> result_label == 8'd0)
    else $error("limit stop with nonzero label");

  // a label taken from a node means at least one visit
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_LEAF || status == STAT_UNKNOWN) |-> visits != 11'd0)
    else $error("node label result without a visit");

endmodule

bind decision_tree_classify_core dtc_check u_dtc_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .result_label (result_label),
  .status       (status),
  .visits       (visits)
);

/* verif/tb_top.sv */
// testbench for the decision tree classifier: directed store writes and walks, then random trees and samples
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtc_pkg::*;

  // node kind 3 is not named in the package; the block walks it like a leaf
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // one request beat, fields in port order
  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  addr;
    logic [1:0]  kind;
    logic [5:0]  feature_sel;
    logic [31:0] value;
    logic [7:0]  label;
    logic [9:0]  link_a;
    logic [9:0]  link_b;
    logic [6:0]  category_count;
  } tree_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  label;
    logic [1:0]  status;
    logic [10:0] visits;
  } verdict_t;

  // first unwritten entry a walk would run into
  typedef enum logic [1:0] {HOLE_NONE, HOLE_NODE, HOLE_FEATURE, HOLE_LINK} hole_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  func;
  logic [9:0]  addr;
  logic [1:0]  kind;
  logic [5:0]  feature_sel;
  logic [31:0] value;
  logic [7:0]  label;
  logic [9:0]  link_a;
  logic [9:0]  link_b;
  logic [6:0]  category_count;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [7:0]  result_label;
  logic [1:0]  status;
  logic [10:0] visits;

  decision_tree_classify_core dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .func           (func),
    .addr           (addr),
    .kind           (kind),
    .feature_sel    (feature_sel),
    .value          (value),
    .label          (label),
    .link_a         (link_a),
    .link_b         (link_b),
    .category_count (category_count),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_label   (result_label),
    .status         (status),
    .visits         (visits)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the tree, the sample and the registers
  // ---------------------------------------------------------------------------
  node_rec_t   node_mem  [NODE_COUNT];
  bit          node_set  [NODE_COUNT];
  logic [9:0]  child_mem [LINK_COUNT];
  bit          child_set [LINK_COUNT];
  logic [31:0] feat_mem  [FEATURE_COUNT];
  bit          feat_set  [FEATURE_COUNT];
  logic [9:0]  model_root  = 10'd0;
  logic [10:0] model_limit = 11'd1024;

  // labels still owed by the block, oldest first
  verdict_t    pending_labels [$];
  int          errors = 0;

  // traffic shape, changed per phase
  int          gap_max;
  int          burst_max;
  int          burst_left = 0;
  int          stall_pct;
  int          stall_run_max;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic verdict_t make_verdict(input logic [7:0] lab, input logic [1:0] st,
                                            input logic [10:0] n);
    return {lab, st, n};
  endfunction

  // walk the shadow tree from the root; stops early at the first unwritten entry
  function automatic hole_t walk_tree(output verdict_t v, output int gap_at);
    logic [9:0]  at;
    logic [10:0] hops;
    node_rec_t   rec;
    logic [31:0] feat;
    logic [9:0]  slot;
    at = model_root;
    hops = '0;
    feat = '0;
    v = make_verdict(8'd0, STAT_LIMIT, 11'd0);
    gap_at = 0;
    for (int step = 0; step <= 2048; step++) begin
      // limit is checked before each visit, so a limit of 0 fails with no visit
      if (hops >= model_limit) begin
        v = make_verdict(8'd0, STAT_LIMIT, hops);
        return HOLE_NONE;
      end
      hops++;
      if (!node_set[at]) begin
        gap_at = int'(at);
        return HOLE_NODE;
      end
      rec = node_mem[at];
      if (rec.kind == KIND_CONT || rec.kind == KIND_CAT) begin
        if (!feat_set[rec.feature_sel]) begin
          gap_at = int'(rec.feature_sel);
          return HOLE_FEATURE;
        end
        feat = feat_mem[rec.feature_sel];
      end
      if (rec.kind == KIND_CONT) begin
        // signed q16.16 compare, ties go left
        at = ($signed(feat) <= $signed(rec.threshold)) ? rec.link_a : rec.link_b;
      end else if (rec.kind == KIND_CAT) begin
        // negative or unknown category code falls back to the majority label
        if (feat[31] || feat >= {25'd0, rec.category_count}) begin
          v = make_verdict(rec.label, STAT_UNKNOWN, hops);
          return HOLE_NONE;
        end
        slot = rec.link_a + feat[9:0];  // wraps around the link store
        if (!child_set[slot]) begin
          gap_at = int'(slot);
          return HOLE_LINK;
        end
        at = child_mem[slot];
      end else begin
        // leaf, and kind 3 as well
        v = make_verdict(rec.label, STAT_LEAF, hops);
        return HOLE_NONE;
      end
    end
    return HOLE_NONE;
  endfunction

  // update the shadow state for an accepted beat and queue its result
  function automatic void take_item(input tree_item_t it);
    node_rec_t rec;
    verdict_t  v;
    int        gap_at;
    v = make_verdict(8'd0, STAT_WRITE_DONE, 11'd0);
    case (it.func)
      FN_NODE: begin
        rec.kind           = it.kind;
        rec.feature_sel    = it.feature_sel;
        rec.threshold      = it.value;
        rec.label          = it.label;
        rec.link_a         = it.link_a;
        rec.link_b         = it.link_b;
        // oversized category counts are clipped on write
        rec.category_count = (it.category_count > CATEGORY_MAX) ?
                             7'(CATEGORY_MAX) : it.category_count;
        node_mem[it.addr] = rec;
        node_set[it.addr] = 1'b1;
      end
      FN_LINK: begin
        child_mem[it.addr] = it.link_a;
        child_set[it.addr] = 1'b1;
      end
      FN_FEATURE: begin
        // feature index beyond the store: dropped, still answered
        if (it.addr < FEATURE_COUNT) begin
          feat_mem[it.addr[5:0]] = it.value;
          feat_set[it.addr[5:0]] = 1'b1;
        end
      end
      default: begin
        if (walk_tree(v, gap_at) != HOLE_NONE)
          flag_error("classify beat sent onto an unwritten entry");
      end
    endcase
    pending_labels.insert(pending_labels.size(), v);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_now  = 1'b0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_now  = ($urandom_range(0, 99) < stall_pct);
      stall_left = $urandom_range(1, stall_run_max);
    end else begin
      stall_left--;
    end
    rsp_stall <= stall_now;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_labels.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending: label %0d status %0d visits %0d",
                             result_label, status, visits));
      end else begin
        want = pending_labels.pop_front();
        if (result_label !== want.label || status !== want.status || visits !== want.visits)
          flag_error($sformatf({"result beat: expected label %0d status %0d visits %0d,",
                                " got label %0d status %0d visits %0d"},
                               want.label, want.status, want.visits,
                               result_label, status, visits));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  function automatic void set_traffic(input int gap, input int burst, input int pct,
                                      input int run);
    gap_max       = gap;
    burst_max     = burst;
    stall_pct     = pct;
    stall_run_max = run;
  endfunction

  // one beat, in bursts with random gaps; state is updated at acceptance
  task automatic send_item(input tree_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        req_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    @(negedge clk);
    {func, addr, kind, feature_sel, value, label, link_a, link_b, category_count} = it;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    take_item(it);
  endtask

  // drop valid and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    req_valid  = 1'b0;
    burst_left = 0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write, then read back; upper pwdata bits carry junk the register must drop
  task automatic write_reg(input logic sel, input logic [10:0] data);
    logic [31:0] mask;
    mask = (sel == REG_ROOT) ? 32'h3FF : 32'h7FF;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = ($urandom & ~mask) | ({21'd0, data} & mask);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_ROOT) model_root = data[9:0];
    else model_limit = data;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== ({21'd0, data} & mask))
      flag_error($sformatf("register at %0d reads %0h, expected %0h", {sel, 2'b00},
                           prdata & mask, {21'd0, data} & mask));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // beat builders
  // ---------------------------------------------------------------------------
  function automatic tree_item_t scrambled();
    tree_item_t it;
    it.func           = 2'($urandom_range(0, 3));
    it.addr           = 10'($urandom_range(0, 1023));
    it.kind           = 2'($urandom_range(0, 3));
    it.feature_sel    = 6'($urandom_range(0, 63));
    it.value          = $urandom;
    it.label          = 8'($urandom_range(0, 255));
    it.link_a         = 10'($urandom_range(0, 1023));
    it.link_b         = 10'($urandom_range(0, 1023));
    it.category_count = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic tree_item_t node_item(input logic [9:0] at, input logic [1:0] k,
                                           input logic [5:0] sel, input logic [31:0] thr,
                                           input logic [7:0] lab, input logic [9:0] la,
                                           input logic [9:0] lb, input logic [6:0] cnt);
    tree_item_t it;
    it = scrambled();
    it.func           = FN_NODE;
    it.addr           = at;
    it.kind           = k;
    it.feature_sel    = sel;
    it.value          = thr;
    it.label          = lab;
    it.link_a         = la;
    it.link_b         = lb;
    it.category_count = cnt;
    return it;
  endfunction

  function automatic tree_item_t link_item(input logic [9:0] slot, input logic [9:0] target);
    tree_item_t it;
    it = scrambled();
    it.func   = FN_LINK;
    it.addr   = slot;
    it.link_a = target;
    return it;
  endfunction

  function automatic tree_item_t feature_item(input logic [9:0] idx, input logic [31:0] val);
    tree_item_t it;
    it = scrambled();
    it.func  = FN_FEATURE;
    it.addr  = idx;
    it.value = val;
    return it;
  endfunction

  // many small codes so categorical nodes follow links, plus small negatives, the signed extremes and random words
  function automatic logic [31:0] sample_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 70);
      4:          return 32'd0 - $urandom_range(1, 8);
      5:          return 32'h8000_0000;
      6:          return 32'h7FFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  // a plausible node: mixed kinds, small category counts, random children
  function automatic tree_item_t grown_node(input logic [9:0] at);
    int         pick;
    logic [1:0] k;
    logic [6:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 35) k = KIND_LEAF;
    else if (pick < 75) k = KIND_CONT;
    else if (pick < 95) k = KIND_CAT;
    else k = KIND_SPARE;
    cnt = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(1, 16)) :
                                        7'($urandom_range(0, 127));
    return node_item(at, k, 6'($urandom_range(0, 63)), sample_value(),
                     8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), cnt);
  endfunction

  // fill in whatever the walk would read unwritten, then classify
  task automatic classify_sample();
    verdict_t   v;
    int         gap_at;
    hole_t      hole;
    tree_item_t it;
    hole = walk_tree(v, gap_at);
    while (hole != HOLE_NONE) begin
      case (hole)
        HOLE_NODE:    send_item(grown_node(10'(gap_at)));
        HOLE_FEATURE: send_item(feature_item(10'(gap_at), sample_value()));
        default:      send_item(link_item(10'(gap_at), 10'($urandom_range(0, 1023))));
      endcase
      hole = walk_tree(v, gap_at);
    end
    it = scrambled();
    it.func = FN_CLASSIFY;
    send_item(it);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_store_writes();
    send_item(feature_item(10'd63, 32'h7FFF_FFFF));
    // feature index past the store: ignored
    send_item(feature_item(10'd1023, 32'hFFFF_FFFF));
    send_item(link_item(10'd1023, 10'h3FF));
    // all ones, category count clipped
    send_item(node_item(10'd1023, KIND_SPARE, 6'd63, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 10'h3FF,
                        7'h7F));
  endtask

  task automatic test_split_rules();
    // continuous root on a feature equal to the threshold: left
    send_item(node_item(10'd0, KIND_CONT, 6'd63, 32'h7FFF_FFFF, 8'hFF, 10'd1, 10'd2, 7'd0));
    send_item(node_item(10'd1, KIND_LEAF, 6'd0, 32'd0, 8'hAA, 10'd0, 10'd0, 7'd0));
    send_item(node_item(10'd2, KIND_SPARE, 6'd0, 32'd0, 8'h55, 10'd0, 10'd0, 7'd127));
    classify_sample();
    // one below: right, into a kind 3 node
    send_item(node_item(10'd0, KIND_CONT, 6'd63, 32'h7FFF_FFFE, 8'hFF, 10'd1, 10'd2, 7'd0));
    classify_sample();
    // categorical root, most negative code
    send_item(feature_item(10'd62, 32'h8000_0000));
    send_item(node_item(10'd0, KIND_CAT, 6'd62, 32'd0, 8'h3C, 10'd1020, 10'd0, 7'd127));
    classify_sample();
    // valid code whose slot wraps past the link store end
    send_item(feature_item(10'd62, 32'd5));
    send_item(link_item(10'd1, 10'd1));
    classify_sample();
    // code equal to the clipped count
    send_item(feature_item(10'd62, 32'd64));
    classify_sample();
  endtask

  task automatic test_visit_limit();
    // node 3 loops to itself
    send_item(node_item(10'd3, KIND_CONT, 6'd63, 32'd0, 8'h77, 10'd3, 10'd3, 7'd0));
    drain_results();
    write_reg(REG_ROOT, 11'd3);
    write_reg(REG_LIMIT, 11'd5);
    classify_sample();
    drain_results();
    write_reg(REG_LIMIT, 11'd0);
    classify_sample();
    drain_results();
    write_reg(REG_ROOT, 11'd1);
    write_reg(REG_LIMIT, 11'd1);
    classify_sample();
  endtask

  task automatic test_random_trees();
    logic [10:0] root;
    logic [10:0] limit;
    int          n;
    int          pick;
    tree_item_t  it;
    for (int phase = 0; phase < 7; phase++) begin
      root = 11'($urandom_range(0, 1023));
      case (phase)
        0: begin
          limit = 11'($urandom_range(2, 40));
          set_traffic(3, 8, 30, 4);
          n = 250;
        end
        1: begin
          root  = 11'd0;
          limit = 11'd1024;
          set_traffic(0, 1, 0, 1);
          n = 120;
        end
        2: begin
          root  = 11'd1023;
          limit = 11'($urandom_range(1, 6));
          set_traffic(12, 3, 60, 10);
          n = 200;
        end
        3: begin
          limit = 11'd2047;
          set_traffic(2, 16, 20, 3);
          n = 50;
        end
        4: begin
          limit = 11'd0;
          set_traffic(4, 4, 50, 6);
          n = 40;
        end
        5: begin
          limit = 11'($urandom_range(2, 40));
          set_traffic(6, 12, 40, 8);
          n = 280;
        end
        default: begin
          limit = 11'd1;
          set_traffic(1, 20, 10, 2);
          n = 60;
        end
      endcase
      drain_results();
      write_reg(REG_ROOT, root);
      write_reg(REG_LIMIT, limit);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          classify_sample();
        end else if (pick < 70) begin
          send_item(feature_item(10'(($urandom_range(0, 9) == 0) ? $urandom_range(64, 1023) :
                                     $urandom_range(0, 63)), sample_value()));
        end else if (pick < 85) begin
          // reshape part of the tree
          send_item(grown_node(10'($urandom_range(0, 1023))));
        end else begin
          // raw writes with every field random
          it = scrambled();
          if (it.func == FN_CLASSIFY) it.func = FN_LINK;
          send_item(it);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_valid = 1'b0;
    {func, addr, kind, feature_sel, value, label, link_a, link_b, category_count} = '0;
    set_traffic(2, 6, 25, 3);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_store_writes();
    test_split_rules();
    test_visit_limit();
    test_random_trees();

    // everything back, then room for any stray beat
    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
